/* rtl/bpt_pkg.sv */
// Package: beat types, widths and helpers for the barycentric point-in-triangle block.
package bpt_pkg;

  localparam int CW    = 16;        // coordinate width
  localparam int SW    = CW + 1;    // coordinate difference
  localparam int PW    = 2 * SW;    // product of two differences
  localparam int AW    = PW + 1;    // sum of two products
  localparam int NW    = AW + 2;    // numerator / denominator, common width
  localparam int MW    = NW - 1;    // magnitude width
  localparam int RW    = MW + 1;    // divider partial remainder
  localparam int FRAC  = 16;        // fraction bits of a weight
  localparam int WW    = 20;        // weight width
  localparam int STEPS = WW;        // one quotient bit per divider stage
  localparam int LOWB  = WW - FRAC; // numerator bits shifted in by the divider

  typedef struct packed {
    logic [CW-1:0] vertex_a_x;
    logic [CW-1:0] vertex_a_y;
    logic [CW-1:0] vertex_b_x;
    logic [CW-1:0] vertex_b_y;
    logic [CW-1:0] vertex_c_x;
    logic [CW-1:0] vertex_c_y;
    logic [CW-1:0] query_x;
    logic [CW-1:0] query_y;
  } in_t;

  typedef struct packed {
    logic signed [WW-1:0] weight_a;
    logic signed [WW-1:0] weight_b;
    logic signed [WW-1:0] weight_c;
    logic                 inside_res;
    logic                 degenerate;
  } out_t;

  // one weight being divided
  typedef struct packed {
    logic [RW-1:0] rem;
    logic [WW-1:0] nbits;
    logic [WW-1:0] q;
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]   lane;
    logic [MW-1:0] dmag;
    logic          deg;
    logic          in_tri;
  } div_t;

  function automatic logic [MW-1:0] mag(input logic [NW-1:0] v);
    logic [NW-1:0] t;
    t = v[NW-1] ? (~v + NW'(1)) : v;
    return t[MW-1:0];
  endfunction

  // 0 <= n/d <= 1, exact
  function automatic logic in_unit(input logic signed [NW-1:0] n,
                                   input logic signed [NW-1:0] d);
    logic r;
    if (d[NW-1]) r = (n <= 0) && (n >= d);
    else         r = (n >= 0) && (n <= d);
    return r;
  endfunction

endpackage

/* rtl/barycentric_point_in_triangle.sv */
// Top level: barycentric weights and inside test for a 2D triangle, fully pipelined.
//
// Input channel (in_valid / in_stall / in_data): one beat carries the three
// vertices and the query point, signed Q11.4. Output channel (out_valid /
// out_stall / out_data): one beat per input beat, in order, with the three
// weights (signed Q3.16, truncated toward zero, saturated), the inside flag
// and the degenerate flag (zero denominator: weights zero, inside clear).
// Depth: 26 register stages - five front stages (differences, 17x17
// products, sums, third numerator, magnitudes and divider set-up), twenty
// restoring-division stages (one quotient bit per stage, all three weights
// side by side) and the output register.
// Throughput: one beat per cycle while no result is held under out_stall; the division stages set the depth.
// Stall: the pipeline advances as a whole; while a result sits in the output
// register with out_stall high, every stage holds and in_stall is raised, so
// nothing is lost or repeated.
// Reset: synchronous, active low; clears the valid bits only, the datapath
// needs no reset.
module barycentric_point_in_triangle
  import bpt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic en;
  logic vld [STEPS+1];
  div_t pp  [STEPS+1];
  logic out_valid_r;
  out_t out_r;
  out_t out_nxt;
  logic [WW-1:0] wq [3];
  lane_t ln;

  // whole pipeline moves unless a result is held at the output
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  bpt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .in_p    (in_data),
    .out_vld (vld[0]),
    .out_p   (pp[0])
  );

  for (genvar g = 0; g < STEPS; g++) begin : g_div
    bpt_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (vld[g]),
      .in_p    (pp[g]),
      .out_vld (vld[g+1]),
      .out_p   (pp[g+1])
    );
  end

  // sign and saturation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ln = pp[STEPS].lane[i];
      if (pp[STEPS].deg) begin
        wq[i] = '0;
      end else if (ln.neg) begin
        if (ln.ovf || (ln.q > {1'b1, {(WW-1){1'b0}}})) wq[i] = {1'b1, {(WW-1){1'b0}}};
        else                                          wq[i] = ~ln.q + WW'(1);
      end else begin
        if (ln.ovf || ln.q[WW-1]) wq[i] = {1'b0, {(WW-1){1'b1}}};
        else                      wq[i] = ln.q;
      end
    end
    out_nxt.weight_a   = wq[0];
    out_nxt.weight_b   = wq[1];
    out_nxt.weight_c   = wq[2];
    out_nxt.inside_res = pp[STEPS].in_tri && !pp[STEPS].deg;
    out_nxt.degenerate = pp[STEPS].deg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.weight_a == '0 && out_data.weight_b == '0 &&
      out_data.weight_c == '0 && !out_data.inside_res)
    else $error("degenerate beat with nonzero weights");
  a_inside_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.inside_res |->
      !out_data.weight_a[WW-1] && !out_data.weight_b[WW-1] && !out_data.weight_c[WW-1])
    else $error("inside beat with a negative weight");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed under stall");
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output hold");
`endif

endmodule

/* rtl/bpt_front.sv */
// Front pipeline: differences, products, sums, numerators and divider set-up.
module bpt_front
  import bpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  in_t   in_p,
  output logic  out_vld,
  output div_t  out_p
);

  // stage 1: edge differences
  logic signed [SW-1:0] e0_r, e1_r, e2_r, e3_r, f_r, qx_r, qy_r;
  logic                 v1_r;
  // stage 2: products
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic                 v2_r;
  // stage 3: sums
  logic signed [AW-1:0] d_r, na_r, nb_r;
  logic                 v3_r;
  // stage 4: third numerator
  logic signed [NW-1:0] d4_r, na4_r, nb4_r, nc4_r;
  logic                 v4_r;
  // stage 5
  div_t                 p5s_r;
  logic                 v5_r;

  logic signed [PW-1:0] p0_nxt, p1_nxt, p2_nxt, p3_nxt, p4_nxt, p5_nxt;
  logic signed [NW-1:0] dx, nax, nbx;
  div_t                 p5s_nxt;
  logic [MW-1:0]        um [3];
  logic signed [NW-1:0] nv [3];

  function automatic logic signed [SW-1:0] dif(input logic [CW-1:0] a,
                                               input logic [CW-1:0] b);
    return {a[CW-1], a} - {b[CW-1], b};
  endfunction

  assign p0_nxt = e0_r * e3_r;
  assign p1_nxt = e1_r * f_r;
  assign p2_nxt = e0_r * qx_r;
  assign p3_nxt = e1_r * qy_r;
  assign p4_nxt = e2_r * qx_r;
  assign p5_nxt = e3_r * qy_r;

  assign dx  = {{(NW-AW){d_r[AW-1]}},  d_r};
  assign nax = {{(NW-AW){na_r[AW-1]}}, na_r};
  assign nbx = {{(NW-AW){nb_r[AW-1]}}, nb_r};

  assign nv[0] = na4_r;
  assign nv[1] = nb4_r;
  assign nv[2] = nc4_r;

  always_comb begin
    p5s_nxt.dmag   = mag(d4_r);
    p5s_nxt.deg    = (d4_r == '0);
    p5s_nxt.in_tri = in_unit(na4_r, d4_r) && in_unit(nb4_r, d4_r) &&
                     in_unit(nc4_r, d4_r);
    for (int i = 0; i < 3; i++) begin
      um[i] = mag(nv[i]);
      p5s_nxt.lane[i].rem   = {{LOWB{1'b0}}, 1'b0, um[i][MW-1:LOWB]};
      p5s_nxt.lane[i].nbits = {um[i][LOWB-1:0], {FRAC{1'b0}}};
      p5s_nxt.lane[i].q     = '0;
      p5s_nxt.lane[i].neg   = nv[i][NW-1] != d4_r[NW-1];
      p5s_nxt.lane[i].ovf   = {{LOWB{1'b0}}, um[i]} >= {p5s_nxt.dmag, {LOWB{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0_r  <= dif(in_p.vertex_b_y, in_p.vertex_c_y);
      e1_r  <= dif(in_p.vertex_c_x, in_p.vertex_b_x);
      e2_r  <= dif(in_p.vertex_c_y, in_p.vertex_a_y);
      e3_r  <= dif(in_p.vertex_a_x, in_p.vertex_c_x);
      f_r   <= dif(in_p.vertex_a_y, in_p.vertex_c_y);
      qx_r  <= dif(in_p.query_x,    in_p.vertex_c_x);
      qy_r  <= dif(in_p.query_y,    in_p.vertex_c_y);
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      p3_r  <= p3_nxt;
      p4_r  <= p4_nxt;
      p5_r  <= p5_nxt;
      d_r   <= {p0_r[PW-1], p0_r} + {p1_r[PW-1], p1_r};
      na_r  <= {p2_r[PW-1], p2_r} + {p3_r[PW-1], p3_r};
      nb_r  <= {p4_r[PW-1], p4_r} + {p5_r[PW-1], p5_r};
      d4_r  <= dx;
      na4_r <= nax;
      nb4_r <= nbx;
      nc4_r <= dx - nax - nbx;
      p5s_r <= p5s_nxt;
    end
  end

  assign out_vld = v5_r;
  assign out_p   = p5s_r;

endmodule

/* rtl/bpt_div_step.sv */
// One restoring-division stage: one quotient bit for each of the three weights.
module bpt_div_step
  import bpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  div_t  in_p,
  output logic  out_vld,
  output div_t  out_p
);

  div_t          nxt;
  logic [RW-1:0] t [3];
  logic          v_r;
  div_t          p_r;

  always_comb begin
    nxt = in_p;
    for (int i = 0; i < 3; i++) begin
      t[i] = {in_p.lane[i].rem[RW-2:0], in_p.lane[i].nbits[WW-1]};
      nxt.lane[i].nbits = {in_p.lane[i].nbits[WW-2:0], 1'b0};
      if (t[i] >= {1'b0, in_p.dmag}) begin
        nxt.lane[i].rem = t[i] - {1'b0, in_p.dmag};
        nxt.lane[i].q   = {in_p.lane[i].q[WW-2:0], 1'b1};
      end else begin
        nxt.lane[i].rem = t[i];
        nxt.lane[i].q   = {in_p.lane[i].q[WW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= nxt;
    end
  end

  assign out_vld = v_r;
  assign out_p   = p_r;

endmodule
